[rtl/tcpoa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tcpoa_pkg;

    // Status codes of a result
    localparam logic [2:0] ST_FOUND    = 3'd0;
    localparam logic [2:0] ST_EOL      = 3'd1;
    localparam logic [2:0] ST_SHORTLEN = 3'd2;
    localparam logic [2:0] ST_PARTIAL  = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // Configuration register indexes
    localparam logic CFG_MATCH_KIND   = 1'b0;
    localparam logic CFG_MATCH_LENGTH = 1'b1;

    localparam logic [7:0] MATCH_KIND_RESET   = 8'd200;
    localparam logic [5:0] MATCH_LENGTH_RESET = 6'd8;

    // Option kinds with fixed meaning
    localparam logic [7:0] KIND_EOL = 8'd0;
    localparam logic [7:0] KIND_NOP = 8'd1;

    // Smallest legal option length (kind + length bytes)
    localparam logic [7:0] LEN_MIN = 8'd2;

    // Body layout of the address option: port bytes, then address bytes
    localparam logic [2:0] PORT_BYTES    = 3'd2;
    localparam logic [2:0] CAPTURE_BYTES = 3'd6;

    typedef struct packed {
        logic [7:0] option_byte;
        logic       byte_valid;
        logic       area_end;
    } item_t;

    typedef struct packed {
        logic [15:0] client_port;
        logic [31:0] client_address;
        logic [2:0]  status;
    } result_t;

endpackage

`default_nettype wire

[rtl/tcpoa_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcpoa_parser
    import tcpoa_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    step,
    input  wire item_t   item,
    input  wire logic [7:0] match_kind,
    input  wire logic [5:0] match_length,
    output result_t      result
);

    localparam logic [2:0] PH_KIND    = 3'd0;
    localparam logic [2:0] PH_LEN_HIT = 3'd1;
    localparam logic [2:0] PH_LEN_OTH = 3'd2;
    localparam logic [2:0] PH_SKIP    = 3'd3;
    localparam logic [2:0] PH_CAPTURE = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;

    logic [2:0]  phase_reg, phase_next, phase_byte;
    logic [7:0]  body_left_reg, body_left_next, body_left_byte;
    logic [2:0]  count_reg, count_next, count_byte;
    logic [15:0] port_reg, port_next, port_byte;
    logic [31:0] addr_reg, addr_next, addr_byte;
    logic [2:0]  verdict_reg, verdict_next, verdict_byte;
    logic [2:0]  status;
    logic        found;

    // Walk state after the current byte
    always_comb begin
        phase_byte     = phase_reg;
        body_left_byte = body_left_reg;
        count_byte     = count_reg;
        port_byte      = port_reg;
        addr_byte      = addr_reg;
        verdict_byte   = verdict_reg;
        if (item.byte_valid) begin
            unique case (phase_reg)
                PH_KIND: begin
                    if (item.option_byte == KIND_EOL) begin
                        verdict_byte = ST_EOL;
                        phase_byte   = PH_DONE;
                    end else if (item.option_byte != KIND_NOP) begin
                        phase_byte = (item.option_byte == match_kind) ? PH_LEN_HIT
                                                                      : PH_LEN_OTH;
                    end
                end
                PH_LEN_HIT, PH_LEN_OTH: begin
                    if (item.option_byte < LEN_MIN) begin
                        verdict_byte = ST_SHORTLEN;
                        phase_byte   = PH_DONE;
                    end else begin
                        body_left_byte = item.option_byte - LEN_MIN;
                        if (phase_reg == PH_LEN_HIT &&
                            item.option_byte == {2'b00, match_length}) begin
                            count_byte = 3'd0;
                            if (body_left_byte == 8'd0) begin
                                verdict_byte = ST_FOUND;
                                phase_byte   = PH_DONE;
                            end else begin
                                phase_byte = PH_CAPTURE;
                            end
                        end else begin
                            phase_byte = (body_left_byte == 8'd0) ? PH_KIND : PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    body_left_byte = body_left_reg - 8'd1;
                    if (body_left_byte == 8'd0) begin
                        phase_byte = PH_KIND;
                    end
                end
                PH_CAPTURE: begin
                    if (count_reg < PORT_BYTES) begin
                        port_byte = {port_reg[7:0], item.option_byte};
                    end else if (count_reg < CAPTURE_BYTES) begin
                        addr_byte = {addr_reg[23:0], item.option_byte};
                    end
                    if (count_reg < CAPTURE_BYTES) begin
                        count_byte = count_reg + 3'd1;
                    end
                    body_left_byte = body_left_reg - 8'd1;
                    if (body_left_byte == 8'd0) begin
                        // left-align a short capture into its field
                        case (count_byte)
                            3'd1: begin
                                port_byte = {port_byte[7:0], 8'h00};
                                addr_byte = 32'd0;
                            end
                            3'd2: addr_byte = 32'd0;
                            3'd3: addr_byte = {addr_byte[7:0], 24'h000000};
                            3'd4: addr_byte = {addr_byte[15:0], 16'h0000};
                            3'd5: addr_byte = {addr_byte[23:0], 8'h00};
                            default: ;
                        endcase
                        verdict_byte = ST_FOUND;
                        phase_byte   = PH_DONE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        if (phase_byte == PH_DONE) begin
            status = verdict_byte;
        end else if (phase_byte == PH_KIND) begin
            status = ST_NOTFOUND;
        end else begin
            status = ST_PARTIAL;
        end
        found                 = (status == ST_FOUND);
        result.status         = status;
        result.client_address = found ? addr_byte : 32'd0;
        result.client_port    = found ? port_byte : 16'd0;
    end

    // Clear the walk at the end of every area
    always_comb begin
        if (item.area_end) begin
            phase_next     = PH_KIND;
            body_left_next = 8'd0;
            count_next     = 3'd0;
            port_next      = 16'd0;
            addr_next      = 32'd0;
            verdict_next   = ST_NOTFOUND;
        end else begin
            phase_next     = phase_byte;
            body_left_next = body_left_byte;
            count_next     = count_byte;
            port_next      = port_byte;
            addr_next      = addr_byte;
            verdict_next   = verdict_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_KIND;
            body_left_reg <= 8'd0;
            count_reg     <= 3'd0;
            port_reg      <= 16'd0;
            addr_reg      <= 32'd0;
            verdict_reg   <= ST_NOTFOUND;
        end else if (step) begin
            phase_reg     <= phase_next;
            body_left_reg <= body_left_next;
            count_reg     <= count_next;
            port_reg      <= port_next;
            addr_reg      <= addr_next;
            verdict_reg   <= verdict_next;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.area_end |=> phase_reg == PH_KIND && count_reg == 3'd0 &&
                                  port_reg == 16'd0 && addr_reg == 32'd0)
        else $error("walk state not cleared after area end");

    a_body_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SKIP || phase_reg == PH_CAPTURE |-> body_left_reg != 8'd0)
        else $error("body phase with no body bytes left");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAPTURE_BYTES)
        else $error("capture count past address field");
`endif

endmodule

`default_nettype wire

[rtl/tcp_option_address_extract_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Accepted when              Payload
// s_axis    in         s_axis_tvalid & tready     tdata option_byte, tuser byte_valid,
//                                                 tlast area_end
// m_axis    out        m_axis_tvalid & tready     tdata status, client_address, client_port
// cfg       in         cfg_valid & cfg_ready      cfg_index register, cfg_data value
//
// One option byte per cycle while no area-ending item is held; the parse state is
// computed from the input register and updates on each advance, which sets the rate.
// A result is registered in the output register as the area-ending item advances.
// While a result waits, an area-ending item holds in the input register and the
// input stalls behind it; other items advance without a stall.
// Synchronous active-low reset clears the walk and loads match_kind 200, length 8.
module tcp_option_address_extract_unit
    import tcpoa_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] option_byte
    input  wire logic        s_axis_tuser,   // [0] byte_valid
    input  wire logic        s_axis_tlast,   // area_end

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // [2:0] status, [34:3] client_address,
                                             // [50:35] client_port, [55:51] zero

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

    logic [7:0] match_kind_reg;
    logic [5:0] match_length_reg;

    item_t      in_item_reg;
    logic       in_valid_reg, in_valid_next;
    logic       s_accept, advance;

    result_t    parse_result;
    result_t    out_result_reg;
    logic       out_valid_reg, out_valid_next, out_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_kind_reg   <= MATCH_KIND_RESET;
            match_length_reg <= MATCH_LENGTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MATCH_KIND:   match_kind_reg   <= cfg_data;
                CFG_MATCH_LENGTH: match_length_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Hold an area-ending item while the previous result is not taken
    assign advance       = in_valid_reg &&
                           (!in_item_reg.area_end || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.option_byte <= s_axis_tdata;
            in_item_reg.byte_valid  <= s_axis_tuser;
            in_item_reg.area_end    <= s_axis_tlast;
        end
    end

    tcpoa_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .item         (in_item_reg),
        .match_kind   (match_kind_reg),
        .match_length (match_length_reg),
        .result       (parse_result)
    );

    assign out_load       = advance && in_item_reg.area_end;
    assign out_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_result_reg <= parse_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_result_reg.client_port,
                            out_result_reg.client_address, out_result_reg.status};

`ifndef SYNTHESIS
    a_end_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && in_item_reg.area_end && out_valid_reg && !m_axis_tready
        |=> in_valid_reg && in_item_reg.area_end)
        else $error("area-ending transaction dropped while result pending");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !out_valid_reg || m_axis_tready)
        else $error("result register overwritten before transaction");

    a_zero_unless_found: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_result_reg.status != ST_FOUND
        |-> out_result_reg.client_address == 32'd0 && out_result_reg.client_port == 16'd0)
        else $error("address fields set on a result that is not a match");
`endif

endmodule

`default_nettype wire
